// File: rtl/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared sizes, codes and the slot entry layout of the quadratic probe
// hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package qpht_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned SLOTS  = 7;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // Item field widths.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned MARK_W = 2;

  // Sized forms of the table size for compares in the datapath.
  localparam logic [SLOT_W:0]   SLOTS_N   = (SLOT_W + 1)'(SLOTS);
  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Reciprocal for key mod SLOTS: the quotient estimate is low by at most one.
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / SLOTS);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // Slot marks.
  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd1;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd2;

  // One slot as held in the table memory.
  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: rtl/qpht_ifs.sv
// ----------------------------------------------------------------------------
// qpht_ifs
// Request and result channels of the quadratic probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none

interface qpht_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [qpht_pkg::OP_W-1:0]             opcode;
  logic [qpht_pkg::KEY_W-1:0]            key;
  logic signed [qpht_pkg::VAL_W-1:0]     entry_value;

  modport source (output valid, opcode, key, entry_value, input ready);
  modport sink   (input valid, opcode, key, entry_value, output ready);
endinterface

interface qpht_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [qpht_pkg::STAT_W-1:0]           status;
  logic signed [qpht_pkg::VAL_W-1:0]     read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

`default_nettype wire

// File: rtl/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/quadratic_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing key/value table with quadratic probing. Each item inserts
// or updates, searches or removes one key and yields exactly one result item.
// ----------------------------------------------------------------------------
//
//   Channel  Dir   Handshake      Payload
//   in_i     in    valid/ready    opcode[1:0], key[30:0], entry_value[31:0]
//   out_o    out   valid/ready    status[1:0], read_value[31:0]
//
// After reset a clearing pass marks every slot empty, one slot per cycle,
// and no item is taken during that pass.
// An item passes the hashing states S_HASH_MUL, S_HASH_SCALE and S_HASH_REM
// (key mod SLOTS via a reciprocal multiply), then probes P slots (one memory
// read per cycle, 1 <= P <= SLOTS), then the decision and writeback state
// S_DECIDE. One item is worked on at a time. The result register lets the
// next item be taken while a result still waits; the writeback cycle stalls
// only if the previous result has not been taken yet.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_table_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  qpht_in_if.sink         in_i,
  qpht_out_if.source      out_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_MUL,
    S_HASH_SCALE,
    S_HASH_REM,
    S_PROBE,
    S_DECIDE
  } state_e;

  state_e state_q;

  // Request held for the whole operation.
  logic [qpht_pkg::OP_W-1:0]    op_q;
  logic [qpht_pkg::KEY_W-1:0]   key_q;
  logic [qpht_pkg::VAL_W-1:0]   val_q;

  // Hash pipeline.
  logic [2*qpht_pkg::KEY_W-1:0] prod_q;
  logic [qpht_pkg::KEY_W:0]     qs_q;
  logic [qpht_pkg::KEY_W-1:0]   quot_c;
  logic [qpht_pkg::KEY_W:0]     rem_c;
  logic [qpht_pkg::SLOT_W:0]    rem_n_c;
  logic [qpht_pkg::SLOT_W:0]    rem_wrap_c;
  logic [qpht_pkg::SLOT_W-1:0]  home_c;

  // Probe walk.
  logic [qpht_pkg::SLOT_W-1:0]  clr_q;
  logic [qpht_pkg::SLOT_W-1:0]  probe_slot_q;
  logic [qpht_pkg::SLOT_W-1:0]  step_q;
  logic [qpht_pkg::CNT_W-1:0]   iss_cnt_q;
  logic [qpht_pkg::CNT_W-1:0]   chk_cnt_q;
  logic                         rd_pend_q;
  logic [qpht_pkg::SLOT_W-1:0]  pend_slot_q;
  logic [qpht_pkg::SLOT_W:0]    slot_sum_c;
  logic [qpht_pkg::SLOT_W:0]    slot_wrap_c;
  logic [qpht_pkg::SLOT_W-1:0]  slot_nxt_c;
  logic [qpht_pkg::SLOT_W:0]    step_sum_c;
  logic [qpht_pkg::SLOT_W:0]    step_wrap_c;
  logic [qpht_pkg::SLOT_W-1:0]  step_nxt_c;

  // Probe findings.
  logic                         found_q;
  logic [qpht_pkg::SLOT_W-1:0]  hit_slot_q;
  logic [qpht_pkg::VAL_W-1:0]   hit_val_q;
  logic                         free_vld_q;
  logic [qpht_pkg::SLOT_W-1:0]  free_slot_q;

  // Result register.
  logic                         out_valid_q;
  logic [qpht_pkg::STAT_W-1:0]  out_status_q;
  logic [qpht_pkg::VAL_W-1:0]   out_rv_q;

  // Memory port signals.
  logic                         ram_we_c;
  logic [qpht_pkg::SLOT_W-1:0]  ram_waddr_c;
  qpht_pkg::entry_t             ram_wentry_c;
  logic                         ram_re_c;
  logic [qpht_pkg::SLOT_W-1:0]  ram_raddr_c;
  logic [qpht_pkg::ENTRY_W-1:0] ram_rdata;
  qpht_pkg::entry_t             ent_c;

  // Probe evaluation.
  logic                         hit_c;
  logic                         empty_c;
  logic                         open_c;
  logic                         stop_c;

  // Decision.
  logic                         out_free_c;
  logic                         dec_go_c;
  logic                         dec_we_c;
  logic [qpht_pkg::SLOT_W-1:0]  dec_addr_c;
  qpht_pkg::entry_t             dec_entry_c;
  logic [qpht_pkg::STAT_W-1:0]  dec_status_c;
  logic [qpht_pkg::VAL_W-1:0]   dec_rv_c;

  // Table memory: mark, key and value of every slot.
  qpht_ram #(
    .WIDTH (qpht_pkg::ENTRY_W),
    .DEPTH (qpht_pkg::SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we_c),
    .waddr_i (ram_waddr_c),
    .wdata_i (ram_wentry_c),
    .re_i    (ram_re_c),
    .raddr_i (ram_raddr_c),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_value = $signed(out_rv_q);

  // Home slot: key minus the estimated multiple, then one correction.
  always_comb begin
    quot_c     = prod_q[2*qpht_pkg::KEY_W-1:qpht_pkg::KEY_W];
    rem_c      = {1'b0, key_q} - qs_q;
    rem_n_c    = rem_c[qpht_pkg::SLOT_W:0];
    rem_wrap_c = rem_n_c - qpht_pkg::SLOTS_N;
    home_c     = (rem_n_c >= qpht_pkg::SLOTS_N) ? rem_wrap_c[qpht_pkg::SLOT_W-1:0]
                                                 : rem_n_c[qpht_pkg::SLOT_W-1:0];
  end

  // Next probe slot: home + i*i grows by 2i+1 from one probe to the next.
  always_comb begin
    slot_sum_c  = {1'b0, probe_slot_q} + {1'b0, step_q};
    slot_wrap_c = slot_sum_c - qpht_pkg::SLOTS_N;
    slot_nxt_c  = (slot_sum_c >= qpht_pkg::SLOTS_N) ? slot_wrap_c[qpht_pkg::SLOT_W-1:0]
                                                     : slot_sum_c[qpht_pkg::SLOT_W-1:0];
    step_sum_c  = {1'b0, step_q} + (qpht_pkg::SLOT_W + 1)'(2);
    step_wrap_c = step_sum_c - qpht_pkg::SLOTS_N;
    step_nxt_c  = (step_sum_c >= qpht_pkg::SLOTS_N) ? step_wrap_c[qpht_pkg::SLOT_W-1:0]
                                                     : step_sum_c[qpht_pkg::SLOT_W-1:0];
  end

  // Look at the slot that came back from memory this cycle.
  always_comb begin
    ent_c   = qpht_pkg::entry_t'(ram_rdata);
    hit_c   = rd_pend_q && (ent_c.mark == qpht_pkg::MARK_USED) && (ent_c.key == key_q);
    empty_c = rd_pend_q && (ent_c.mark == qpht_pkg::MARK_EMPTY);
    open_c  = rd_pend_q && (ent_c.mark != qpht_pkg::MARK_USED);
    stop_c  = hit_c || empty_c || (rd_pend_q && (chk_cnt_q == qpht_pkg::LAST_CNT));
  end

  // Final decision from the probe findings.
  always_comb begin
    out_free_c   = !out_valid_q || out_o.ready;
    dec_go_c     = (state_q == S_DECIDE) && out_free_c;
    dec_we_c     = 1'b0;
    dec_addr_c   = hit_slot_q;
    dec_entry_c  = '{mark: qpht_pkg::MARK_USED, key: key_q, value: val_q};
    dec_status_c = qpht_pkg::STAT_MISSING;
    dec_rv_c     = '0;
    case (op_q)
      qpht_pkg::OP_INSERT: begin
        if (found_q) begin
          dec_we_c     = 1'b1;
          dec_status_c = qpht_pkg::STAT_OK;
        end else if (free_vld_q) begin
          dec_we_c     = 1'b1;
          dec_addr_c   = free_slot_q;
          dec_status_c = qpht_pkg::STAT_OK;
        end else begin
          dec_status_c = qpht_pkg::STAT_FULL;
        end
      end
      qpht_pkg::OP_SEARCH: begin
        if (found_q) begin
          dec_status_c = qpht_pkg::STAT_OK;
          dec_rv_c     = hit_val_q;
        end
      end
      qpht_pkg::OP_REMOVE: begin
        if (found_q) begin
          dec_we_c     = 1'b1;
          dec_entry_c  = '{mark: qpht_pkg::MARK_DELETED, key: key_q, value: hit_val_q};
          dec_status_c = qpht_pkg::STAT_OK;
        end
      end
      default: begin
        dec_status_c = qpht_pkg::STAT_MISSING;
      end
    endcase
  end

  // Memory port control: clearing pass, probe reads, writeback.
  always_comb begin
    ram_we_c     = 1'b0;
    ram_waddr_c  = clr_q;
    ram_wentry_c = '{mark: qpht_pkg::MARK_EMPTY, key: '0, value: '0};
    ram_re_c     = (state_q == S_PROBE) && (iss_cnt_q != qpht_pkg::SLOTS_CNT);
    ram_raddr_c  = probe_slot_q;
    if (state_q == S_CLEAR) begin
      ram_we_c = 1'b1;
    end else if (dec_go_c && dec_we_c) begin
      ram_we_c     = 1'b1;
      ram_waddr_c  = dec_addr_c;
      ram_wentry_c = dec_entry_c;
    end
  end

  // Sequencer, probe bookkeeping and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      op_q         <= '0;
      key_q        <= '0;
      val_q        <= '0;
      prod_q       <= '0;
      qs_q         <= '0;
      probe_slot_q <= '0;
      step_q       <= '0;
      iss_cnt_q    <= '0;
      chk_cnt_q    <= '0;
      rd_pend_q    <= 1'b0;
      pend_slot_q  <= '0;
      found_q      <= 1'b0;
      hit_slot_q   <= '0;
      hit_val_q    <= '0;
      free_vld_q   <= 1'b0;
      free_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_rv_q     <= '0;
    end else begin
      // A taken result frees the output register, unless a new result
      // moves in at the same edge.
      if (out_valid_q && out_o.ready && !dec_go_c) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == qpht_pkg::LAST_SLOT) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.opcode;
            key_q   <= in_i.key;
            val_q   <= $unsigned(in_i.entry_value);
            state_q <= S_HASH_MUL;
          end
        end
        S_HASH_MUL: begin
          prod_q  <= key_q * qpht_pkg::RECIP;
          state_q <= S_HASH_SCALE;
        end
        S_HASH_SCALE: begin
          qs_q    <= (qpht_pkg::KEY_W + 1)'(quot_c) * (qpht_pkg::KEY_W + 1)'(qpht_pkg::SLOTS);
          state_q <= S_HASH_REM;
        end
        S_HASH_REM: begin
          probe_slot_q <= home_c;
          step_q       <= qpht_pkg::SLOT_W'(1);
          iss_cnt_q    <= '0;
          chk_cnt_q    <= '0;
          rd_pend_q    <= 1'b0;
          found_q      <= 1'b0;
          free_vld_q   <= 1'b0;
          state_q      <= S_PROBE;
        end
        S_PROBE: begin
          // Issue the next probe read; a finished walk drops any read still
          // in flight.
          rd_pend_q <= ram_re_c && !stop_c;
          if (ram_re_c) begin
            pend_slot_q  <= probe_slot_q;
            probe_slot_q <= slot_nxt_c;
            step_q       <= step_nxt_c;
            iss_cnt_q    <= iss_cnt_q + 1'b1;
          end
          // Evaluate the slot read in the previous cycle.
          if (rd_pend_q) begin
            chk_cnt_q <= chk_cnt_q + 1'b1;
          end
          if (open_c && !free_vld_q) begin
            free_vld_q  <= 1'b1;
            free_slot_q <= pend_slot_q;
          end
          if (stop_c) begin
            found_q    <= hit_c;
            hit_slot_q <= pend_slot_q;
            hit_val_q  <= ent_c.value;
            state_q    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_go_c) begin
            out_valid_q  <= 1'b1;
            out_status_q <= dec_status_c;
            out_rv_q     <= dec_rv_c;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // A result appears only out of the decision cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DECIDE))
    else $error("Result raised outside the decision cycle.");

  // The table is never written while a probe walk reads it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> !ram_we_c)
    else $error("Table written during a probe walk.");

  // Only a successful search carries a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != qpht_pkg::STAT_OK)) |-> (out_rv_q == '0))
    else $error("Nonzero value with a failing status.");

  // The walk never reads more slots than the table holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (iss_cnt_q <= qpht_pkg::SLOTS_CNT))
    else $error("Probe walk ran past the table size.");

endmodule

`default_nettype wire

// File: tb/sv/qpht_table_checker.sv
// ----------------------------------------------------------------------------
// qpht_table_checker
// Watches both channels of the hash table core, keeps its own copy of the
// table to predict each result item, and compares every result item with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module qpht_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qpht_in_if          req_i,
  qpht_out_if         res_i,
  output int unsigned mismatch_o,
  output int unsigned outstanding_o,
  output int unsigned ok_cnt_o,
  output int unsigned missing_cnt_o,
  output int unsigned full_cnt_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [qpht_pkg::STAT_W-1:0]       status;
    logic signed [qpht_pkg::VAL_W-1:0] read_value;
  } result_t;

  // Shadow copy of the table.
  logic [qpht_pkg::MARK_W-1:0] tbl_mark [qpht_pkg::SLOTS];
  logic [qpht_pkg::KEY_W-1:0]  tbl_key  [qpht_pkg::SLOTS];
  logic [qpht_pkg::VAL_W-1:0]  tbl_val  [qpht_pkg::SLOTS];

  result_t     pending_results [$];
  result_t     got;
  result_t     want;
  int unsigned errs;
  int unsigned n_ok;
  int unsigned n_missing;
  int unsigned n_full;

  // Applies one operation to the shadow table and returns the result item
  // that the core must produce for it.
  function automatic result_t table_apply(logic [qpht_pkg::OP_W-1:0] op,
                                          logic [qpht_pkg::KEY_W-1:0] key,
                                          logic [qpht_pkg::VAL_W-1:0] val);
    result_t r;
    int      home;
    int      slot;
    int      hit;
    int      free_slot;
    int      i;
    bit      stop;
    r.status     = qpht_pkg::STAT_MISSING;
    r.read_value = '0;
    hit          = -1;
    free_slot    = -1;
    stop         = 1'b0;
    home         = int'(key % qpht_pkg::SLOTS);

    // Walk the probe sequence; an empty slot ends it, since the key cannot
    // lie further on. The first free slot seen is remembered for insert.
    for (i = 0; i < qpht_pkg::SLOTS && !stop; i++) begin
      slot = (home + (i * i) % qpht_pkg::SLOTS) % qpht_pkg::SLOTS;
      if (tbl_mark[slot] == qpht_pkg::MARK_EMPTY) begin
        if (free_slot < 0) free_slot = slot;
        stop = 1'b1;
      end else if (tbl_mark[slot] == qpht_pkg::MARK_USED) begin
        if (tbl_key[slot] == key) begin
          hit  = slot;
          stop = 1'b1;
        end
      end else if (free_slot < 0) begin
        free_slot = slot;
      end
    end

    case (op)
      qpht_pkg::OP_INSERT: begin
        if (hit >= 0) begin
          tbl_val[hit] = val;
          r.status     = qpht_pkg::STAT_OK;
        end else if (free_slot >= 0) begin
          tbl_mark[free_slot] = qpht_pkg::MARK_USED;
          tbl_key[free_slot]  = key;
          tbl_val[free_slot]  = val;
          r.status            = qpht_pkg::STAT_OK;
        end else begin
          r.status = qpht_pkg::STAT_FULL;
        end
      end
      qpht_pkg::OP_SEARCH: begin
        if (hit >= 0) begin
          r.read_value = tbl_val[hit];
          r.status     = qpht_pkg::STAT_OK;
        end
      end
      qpht_pkg::OP_REMOVE: begin
        // The value stays behind; only the mark changes.
        if (hit >= 0) begin
          tbl_mark[hit] = qpht_pkg::MARK_DELETED;
          r.status      = qpht_pkg::STAT_OK;
        end
      end
      default: begin
        // The unused code leaves the table alone and reports a miss.
      end
    endcase
    return r;
  endfunction

  // Predict on every accepted request item, compare on every accepted
  // result item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tbl_mark[s]) tbl_mark[s] = qpht_pkg::MARK_EMPTY;
      pending_results.delete();
      errs          = 0;
      n_ok          = 0;
      n_missing     = 0;
      n_full        = 0;
      mismatch_o    <= 0;
      outstanding_o <= 0;
      ok_cnt_o      <= 0;
      missing_cnt_o <= 0;
      full_cnt_o    <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(table_apply(req_i.opcode, req_i.key, req_i.entry_value));
      end
      if (res_i.valid && res_i.ready) begin
        got.status     = res_i.status;
        got.read_value = res_i.read_value;
        if (got.status == qpht_pkg::STAT_OK) n_ok++;
        else if (got.status == qpht_pkg::STAT_MISSING) n_missing++;
        else if (got.status == qpht_pkg::STAT_FULL) n_full++;
        if (pending_results.size() == 0) begin
          $display("%0t: result item with none expected, expected nothing, %s %0d value %0d",
                   $time, "got status", got.status, got.read_value);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            errs++;
          end
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, got %0d",
                     $time, want.read_value, got.read_value);
            errs++;
          end
        end
      end
      mismatch_o    <= errs;
      outstanding_o <= pending_results.size();
      ok_cnt_o      <= n_ok;
      missing_cnt_o <= n_missing;
      full_cnt_o    <= n_full;
    end
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the quadratic probe hash table core. A directed
// run walks through collisions, a full table, deleted slots and misses; a
// random run then hammers a small pool of colliding keys with random
// operations while both sides of the core idle at random.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [qpht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned POOL_SIZE    = 10;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = qpht_pkg::SLOTS + 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  qpht_in_if  req_ch ();
  qpht_out_if res_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned n_ok;
  int unsigned n_missing;
  int unsigned n_full;

  int unsigned n_insert;
  int unsigned n_search;
  int unsigned n_remove;
  int unsigned n_unused;
  int unsigned stall_cycles;
  bit          send_quiet;
  bit          recv_quiet;

  logic [qpht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  quadratic_probe_hash_table_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  qpht_table_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req_ch),
    .res_i         (res_ch),
    .mismatch_o    (mismatches),
    .outstanding_o (outstanding),
    .ok_cnt_o      (n_ok),
    .missing_cnt_o (n_missing),
    .full_cnt_o    (n_full)
  );

  // Idle cycles before the next item; quiet stretches have none.
  function automatic int unsigned pick_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Offers one request item and returns at the edge where it is accepted.
  // The valid stays high into the next item when no gap is drawn.
  task automatic send_item(logic [qpht_pkg::OP_W-1:0] op, logic [qpht_pkg::KEY_W-1:0] key,
                           logic [qpht_pkg::VAL_W-1:0] val);
    int unsigned gap;
    gap = pick_wait(send_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.key         <= key;
    req_ch.entry_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    case (op)
      qpht_pkg::OP_INSERT: n_insert++;
      qpht_pkg::OP_SEARCH: n_search++;
      qpht_pkg::OP_REMOVE: n_remove++;
      default:             n_unused++;
    endcase
  endtask

  // Holds the sender off until every predicted result item has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Keys that mostly share a few home slots, so probing chains build up.
  task automatic refill_pool();
    foreach (key_pool[n]) begin
      if ($urandom_range(0, 3) == 0)
        key_pool[n] = qpht_pkg::KEY_W'($urandom_range(0, 40));
      else
        key_pool[n] = qpht_pkg::KEY_W'(((($urandom & 32'h7fff_ffff) / qpht_pkg::SLOTS)
                                        * qpht_pkg::SLOTS) + $urandom_range(0, 2));
    end
  endtask

  // Request side: reset, directed items, random items, then the verdict.
  initial begin
    logic [qpht_pkg::OP_W-1:0]  op;
    logic [qpht_pkg::KEY_W-1:0] key;
    int unsigned                pick;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= qpht_pkg::OP_INSERT;
    req_ch.key         <= '0;
    req_ch.entry_value <= '0;
    send_quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Misses on an empty table and the unused code.
    send_item(qpht_pkg::OP_SEARCH, '0, 32'h1234_5678);
    send_item(qpht_pkg::OP_REMOVE, '0, '0);
    send_item(OP_UNUSED, 31'h7fff_ffff, 32'hffff_ffff);
    // Extreme keys and values, then an update in place.
    send_item(qpht_pkg::OP_INSERT, '0, 32'h7fff_ffff);
    send_item(qpht_pkg::OP_INSERT, 31'h7fff_ffff, 32'h8000_0000);
    send_item(qpht_pkg::OP_SEARCH, 31'h7fff_ffff, '0);
    send_item(qpht_pkg::OP_INSERT, '0, 32'hffff_ffff);
    send_item(qpht_pkg::OP_SEARCH, '0, 32'h5555_5555);
    // Keys with the same home slot fill the reachable slots until full.
    send_item(qpht_pkg::OP_INSERT, 31'd7, 32'h0000_0007);
    send_item(qpht_pkg::OP_INSERT, 31'd14, 32'h0000_000e);
    send_item(qpht_pkg::OP_INSERT, 31'd21, 32'h0000_0015);
    send_item(OP_UNUSED, '0, '0);
    // A removal leaves a deleted slot that searches pass and inserts reuse.
    send_item(qpht_pkg::OP_REMOVE, 31'd7, '0);
    send_item(qpht_pkg::OP_SEARCH, 31'd14, '0);
    send_item(qpht_pkg::OP_REMOVE, 31'd7, '0);
    send_item(qpht_pkg::OP_SEARCH, 31'd7, '0);
    send_item(qpht_pkg::OP_INSERT, 31'd21, 32'h8000_0001);
    send_item(qpht_pkg::OP_INSERT, 31'd14, 32'haaaa_aaaa);
    send_item(qpht_pkg::OP_SEARCH, 31'd21, '0);
    send_item(qpht_pkg::OP_SEARCH, 31'd14, '0);
    send_item(qpht_pkg::OP_REMOVE, '0, '0);
    send_item(qpht_pkg::OP_SEARCH, '0, '0);
    drain_results();

    // Random operations, mostly on the colliding key pool.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) refill_pool();
      if ($urandom_range(0, 99) == 0) send_quiet = ~send_quiet;
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = qpht_pkg::OP_INSERT;
      else if (pick < 70) op = qpht_pkg::OP_SEARCH;
      else if (pick < 95) op = qpht_pkg::OP_REMOVE;
      else                op = OP_UNUSED;
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else                            key = qpht_pkg::KEY_W'($urandom);
      send_item(op, key, $urandom);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d inserts, %0d searches, %0d removes, %0d unused codes.",
             n_insert + n_search + n_remove + n_unused, n_insert, n_search, n_remove,
             n_unused);
    $display("Results: %0d done or found, %0d key not found, %0d table full.",
             n_ok, n_missing, n_full);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls between result items, with quiet stretches.
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    recv_quiet = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 99) == 0) recv_quiet = ~recv_quiet;
      stall = pick_wait(recv_quiet);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// File: sim.f
rtl/qpht_pkg.sv
rtl/qpht_ifs.sv
rtl/qpht_ram.sv
rtl/quadratic_probe_hash_table_core.sv
tb/sv/qpht_table_checker.sv
tb/sv/tb.sv
